/* sv/ssr_gf16_pkg.sv */
// Shared types, constants and GF(2^16) arithmetic for the secret recombine unit.
`timescale 1ns / 1ps
package ssr_gf16_pkg;

  localparam int GF_W = 16;
  localparam logic [GF_W:0] GF_POLY = 17'h1100b;
  localparam int PROD_W = 2 * GF_W - 1;

  typedef logic [GF_W-1:0] gf_elem_t;
  typedef gf_elem_t xpow_t [PROD_W];

  localparam logic [1:0] FUNC_SET_COORD = 2'd0;
  localparam logic [1:0] FUNC_STORE = 2'd1;
  localparam logic [1:0] FUNC_EXTRACT = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic CFG_SHARE_COUNT = 1'b0;
  localparam logic CFG_WORD_COUNT = 1'b1;

  function automatic xpow_t gf_xpow_init();
    xpow_t t;
    logic [GF_W:0] v;
    v = 17'd1;
    for (int k = 0; k < PROD_W; k++) begin
      t[k] = v[GF_W-1:0];
      v = v << 1;
      if (v[GF_W]) begin
        v = v ^ GF_POLY;
      end
    end
    return t;
  endfunction

  localparam xpow_t GF_XPOW = gf_xpow_init();

  function automatic gf_elem_t gf_mul(gf_elem_t a, gf_elem_t b);
    logic [PROD_W-1:0] c;
    gf_elem_t r;
    c = '0;
    for (int i = 0; i < GF_W; i++) begin
      if (b[i]) begin
        c = c ^ ({{(GF_W-1){1'b0}}, a} << i);
      end
    end
    r = '0;
    for (int k = 0; k < PROD_W; k++) begin
      if (c[k]) begin
        r = r ^ GF_XPOW[k];
      end
    end
    return r;
  endfunction

endpackage

/* sv/ssr_gf16_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ssr_gf16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ssr_gf16_mul.sv */
// Shared GF(2^16) multiplier: carry-less product folded by the field polynomial.
`timescale 1ns / 1ps
module ssr_gf16_mul (
  input  ssr_gf16_pkg::gf_elem_t a,
  input  ssr_gf16_pkg::gf_elem_t b,
  output ssr_gf16_pkg::gf_elem_t p
);

  assign p = ssr_gf16_pkg::gf_mul(a, b);

endmodule

/* sv/shamir_secret_recombine_gf16_unit.sv */
// Top level: slot coordinates, share store and Lagrange recombine sequencer.
// Set and store words finish in the accept cycle; an extract word steps through
//   every slot below n, the active slot count, skipping absent slots, and for each
//   present slot runs products, inverse, numerator and share scaling on the one multiplier.
// Throughput: one extract at a time; busy stays high until done strobes.
// Reset: all slots absent, share_count 16, word_count 256; share store is not cleared.
`timescale 1ns / 1ps
module shamir_secret_recombine_gf16_unit #(
  parameter int MAX_SHARES = 16,
  parameter int MAX_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [3:0]  slot,
  input  logic [7:0]  position,
  input  logic [15:0] x_coord,
  input  logic [15:0] share_word,
  output logic        done,
  output logic [7:0]  position_out,
  output logic [15:0] secret_word,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [8:0]  cfg_wdata
);

  localparam int SW = $clog2(MAX_SHARES);
  localparam int SCW = $clog2(MAX_SHARES + 1);
  localparam int DEPTH = MAX_SHARES * MAX_WORDS;
  localparam int AW = $clog2(DEPTH);
  localparam int INV_STEPS = ssr_gf16_pkg::GF_W - 1;
  localparam ssr_gf16_pkg::gf_elem_t ONE = 16'd1;

  typedef enum logic [2:0] {S_IDLE, S_SLOT, S_PROD, S_INV, S_NUM, S_Y} state_t;

  state_t state;
  logic [4:0] share_count;
  logic [8:0] word_count;
  ssr_gf16_pkg::gf_elem_t coords [MAX_SHARES];
  ssr_gf16_pkg::gf_elem_t num, den, r, t, acc, xi;
  logic [SCW-1:0] i, j, n;
  logic [3:0] k;
  logic phase;
  logic [7:0] pos_r;

  logic accept, pos_ok, slot_ok;
  logic [SW-1:0] rd_idx;
  ssr_gf16_pkg::gf_elem_t x_rd, d, nf, df, mul_a, mul_b, p, ram_rdata;
  logic skip;
  logic [AW-1:0] waddr, raddr;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign pos_ok = ({1'b0, position} < word_count) && (32'(position) < MAX_WORDS);
  assign slot_ok = 32'(slot) < MAX_SHARES;
  assign n = (32'(share_count) > MAX_SHARES) ? SCW'(MAX_SHARES) : SCW'(share_count);

  assign rd_idx = (state == S_SLOT) ? i[SW-1:0] : j[SW-1:0];
  assign x_rd = coords[rd_idx];
  assign d = xi ^ x_rd;
  assign skip = (j == i) || (x_rd == '0);
  assign nf = skip ? ONE : x_rd;
  assign df = (skip || d == '0) ? ONE : d;

  always_comb begin
    mul_a = num;
    mul_b = r;
    case (state)
      S_PROD: begin
        mul_a = phase ? den : num;
        mul_b = phase ? df : nf;
      end
      S_INV: begin
        mul_a = phase ? r : den;
        mul_b = den;
      end
      S_Y: begin
        mul_a = t;
        mul_b = ram_rdata;
      end
      default: begin
        mul_a = num;
        mul_b = r;
      end
    endcase
  end

  ssr_gf16_mul u_mul (
    .a(mul_a),
    .b(mul_b),
    .p(p)
  );

  assign waddr = AW'(32'(slot) * MAX_WORDS + 32'(position));
  assign raddr = AW'(32'(i) * MAX_WORDS + 32'(pos_r));

  ssr_gf16_ram #(
    .WIDTH(ssr_gf16_pkg::GF_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk(clk),
    .we(accept && func == ssr_gf16_pkg::FUNC_STORE && slot_ok && pos_ok),
    .waddr(waddr),
    .wdata(share_word),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      share_count <= 5'd16;
      word_count <= 9'd256;
      for (int s = 0; s < MAX_SHARES; s++) begin
        coords[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ssr_gf16_pkg::CFG_SHARE_COUNT: share_count <= cfg_wdata[4:0];
          ssr_gf16_pkg::CFG_WORD_COUNT: word_count <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && func == ssr_gf16_pkg::FUNC_SET_COORD && slot_ok) begin
        coords[SW'(slot)] <= x_coord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && func == ssr_gf16_pkg::FUNC_EXTRACT && pos_ok) begin
            pos_r <= position;
            acc <= '0;
            i <= '0;
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (i >= n) begin
            done <= 1'b1;
            position_out <= pos_r;
            secret_word <= acc;
            state <= S_IDLE;
          end else if (x_rd == '0) begin
            i <= i + 1'b1;
          end else begin
            xi <= x_rd;
            num <= ONE;
            den <= ONE;
            j <= '0;
            phase <= 1'b0;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          phase <= !phase;
          if (!phase) begin
            num <= p;
          end else begin
            den <= p;
            j <= j + 1'b1;
            if (j == n - 1'b1) begin
              r <= ONE;
              k <= '0;
              state <= S_INV;
            end
          end
        end
        S_INV: begin
          phase <= !phase;
          if (!phase) begin
            den <= p;
          end else begin
            r <= p;
            k <= k + 1'b1;
            if (32'(k) == INV_STEPS - 1) begin
              state <= S_NUM;
            end
          end
        end
        S_NUM: begin
          t <= p;
          state <= S_Y;
        end
        S_Y: begin
          acc <= acc ^ p;
          i <= i + 1'b1;
          state <= S_SLOT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROD || state == S_INV) |-> (num != '0 && den != '0))
    else $error("zero product in coefficient");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROD) |-> (j < n && i < n))
    else $error("slot index out of range");

endmodule

/* bench/shamir_secret_recombine_gf16_unit_test.sv */
// Self-checking bench for the GF(2^16) secret recombine unit: table, pool fill, random phases.
`timescale 1ns / 1ps
module shamir_secret_recombine_gf16_unit_test;

  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 1200;
  localparam int PHASE_ITEMS = 64;

  typedef struct {
    logic [1:0]  fn;
    logic [3:0]  sl;
    logic [7:0]  pos;
    logic [15:0] xc;
    logic [15:0] yw;
    bit          typed;
    logic [15:0] word;
  } row_t;

  typedef struct {
    logic [7:0]  pos;
    logic [15:0] word;
  } secret_t;

  logic clk, rst, start, busy, done, cfg_we, cfg_addr;
  logic [1:0]  func;
  logic [3:0]  slot;
  logic [7:0]  position, position_out;
  logic [15:0] x_coord, share_word, secret_word;
  logic [8:0]  cfg_wdata;

  bit [15:0] coords[16];
  bit [15:0] shares[16][256];
  bit        written[16][256];
  bit [4:0]  n_shares;
  bit [8:0]  n_words;
  secret_t   pending[$];
  int        errors;
  int        quiet;
  bit        idle_en;
  row_t      rows[$];
  logic [7:0] pool[8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd254, 8'd255};
  logic [4:0] cnt_set[6] = '{5'd0, 5'd31, 5'd5, 5'd2, 5'd8, 5'd16};
  logic [8:0] words_set[6] = '{9'd256, 9'd511, 9'd1, 9'd3, 9'd200, 9'd256};

  shamir_secret_recombine_gf16_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .slot(slot),
    .position(position), .x_coord(x_coord), .share_word(share_word), .done(done),
    .position_out(position_out), .secret_word(secret_word), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit [15:0] field_mul(bit [15:0] a, bit [15:0] b);
    bit [16:0] acc;
    bit [16:0] sh;
    acc = '0;
    sh = {1'b0, a};
    for (int i = 0; i < 16; i++) begin
      if (b[i]) acc = acc ^ sh;
      sh = sh << 1;
      if (sh[16]) sh = sh ^ 17'h1100b;
    end
    return acc[15:0];
  endfunction

  function automatic bit [15:0] field_inv(bit [15:0] a);
    bit [15:0] r;
    bit [15:0] base;
    bit [15:0] e;
    r = 16'd1;
    base = a;
    e = 16'hfffe;
    for (int i = 0; i < 16; i++) begin
      if (e[i]) r = field_mul(r, base);
      base = field_mul(base, base);
    end
    return r;
  endfunction

  function automatic bit [15:0] recombine(bit [7:0] pos);
    int n;
    bit [15:0] acc;
    bit [15:0] num;
    bit [15:0] den;
    n = n_shares > 16 ? 16 : n_shares;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      if (coords[i] != 0) begin
        num = 16'd1;
        den = 16'd1;
        for (int j = 0; j < n; j++) begin
          if (j != i && coords[j] != 0) begin
            num = field_mul(num, coords[j]);
            if ((coords[i] ^ coords[j]) != 0) den = field_mul(den, coords[i] ^ coords[j]);
          end
        end
        acc = acc ^ field_mul(shares[i][pos], field_mul(num, field_inv(den)));
      end
    end
    return acc;
  endfunction

  function automatic bit readable(bit [7:0] pos);
    int n;
    n = n_shares > 16 ? 16 : n_shares;
    for (int i = 0; i < n; i++) begin
      if (coords[i] != 0 && !written[i][pos]) return 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send(row_t r);
    secret_t s;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    func <= r.fn;
    slot <= r.sl;
    position <= r.pos;
    x_coord <= r.xc;
    share_word <= r.yw;
    do @(posedge clk); while (busy);
    case (r.fn)
      ssr_gf16_pkg::FUNC_SET_COORD: coords[r.sl] = r.xc;
      ssr_gf16_pkg::FUNC_STORE: begin
        if (r.pos < n_words) begin
          shares[r.sl][r.pos] = r.yw;
          written[r.sl][r.pos] = 1;
        end
      end
      ssr_gf16_pkg::FUNC_EXTRACT: begin
        if (r.pos < n_words) begin
          s.pos = r.pos;
          s.word = r.typed ? r.word : recombine(r.pos);
          pending.push_back(s);
        end
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic addr, logic [8:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == ssr_gf16_pkg::CFG_SHARE_COUNT) n_shares = data[4:0];
    else n_words = data;
    @(posedge clk);
  endtask

  function automatic row_t mk(logic [1:0] fn, logic [3:0] sl, logic [7:0] pos,
                              logic [15:0] xc, logic [15:0] yw, bit typed = 0,
                              logic [15:0] word = 0);
    row_t r;
    r.fn = fn; r.sl = sl; r.pos = pos; r.xc = xc; r.yw = yw;
    r.typed = typed; r.word = word;
    return r;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int pick;
    r = mk(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.fn = ssr_gf16_pkg::FUNC_SET_COORD;
      case ($urandom_range(0, 9))
        0: r.xc = 16'h0000;
        1: r.xc = coords[$urandom_range(0, 15)];
        2: r.xc = 16'hffff;
        default: ;
      endcase
    end else if (pick < 55) begin
      r.fn = ssr_gf16_pkg::FUNC_STORE;
      if ($urandom_range(0, 3) != 0) r.pos = pool[$urandom_range(0, 7)];
    end else if (pick < 92) begin
      r.fn = ssr_gf16_pkg::FUNC_EXTRACT;
      if ($urandom_range(0, 4) != 0) r.pos = pool[$urandom_range(0, 7)];
      if (r.pos < n_words && !readable(r.pos)) r.fn = ssr_gf16_pkg::FUNC_STORE;
    end else begin
      r.fn = ssr_gf16_pkg::FUNC_UNUSED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", secret_word, 16'h0);
      end else begin
        if (position_out != pending[0].pos)
          report_mismatch("position_out", position_out, pending[0].pos);
        if (secret_word != pending[0].word)
          report_mismatch("secret_word", secret_word, pending[0].word);
        void'(pending.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("shamir_secret_recombine_gf16_unit_test: errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1; start = 1'b0; func = '0; slot = '0; position = '0; x_coord = '0;
    share_word = '0; cfg_we = 1'b0; cfg_addr = 1'b0; cfg_wdata = '0;
    errors = 0; quiet = 0; idle_en = 1; n_shares = 16; n_words = 256;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 0, 0, 0, 1, 16'h0000));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 255, 0, 0, 1, 16'h0000));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_SET_COORD, 0, 0, 16'h0001, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 0, 0, 0, 16'hffff));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 0, 0, 0, 1, 16'hffff));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 0, 255, 0, 16'h0000));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 255, 0, 0, 1, 16'h0000));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_SET_COORD, 15, 0, 16'hffff, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 15, 0, 0, 16'h0001));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 15, 255, 0, 16'h8000));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 0, 0, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 255, 0, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_SET_COORD, 3, 0, 16'hffff, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 3, 0, 0, 16'h1234));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 3, 255, 0, 16'habcd));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 0, 0, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 255, 0, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_UNUSED, 15, 255, 16'hffff, 16'hffff));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 0, 10, 0, 16'h0101));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 3, 10, 0, 16'h0303));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 15, 10, 0, 16'hf0f0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_STORE, 7, 10, 0, 16'h5a5a));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_SET_COORD, 7, 0, 16'h8000, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_EXTRACT, 0, 10, 0, 0));
    rows.push_back(mk(ssr_gf16_pkg::FUNC_SET_COORD, 7, 0, 16'h0000, 0));
    foreach (rows[k]) send(rows[k]);

    for (int s = 0; s < 16; s++) begin
      for (int p = 0; p < 8; p++) begin
        send(mk(ssr_gf16_pkg::FUNC_STORE, 4'(s), pool[p], 16'h0000,
                16'($urandom_range(0, 65535))));
      end
    end
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    for (int k = 0; k < PHASE_ITEMS / 2; k++) send(random_row());

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_cfg(ssr_gf16_pkg::CFG_SHARE_COUNT, {4'd0, cnt_set[ph]});
      write_cfg(ssr_gf16_pkg::CFG_WORD_COUNT, words_set[ph]);
      idle_en = (ph != 5);
      for (int k = 0; k < PHASE_ITEMS; k++) send(random_row());
    end
    drain();

    if (errors == 0) begin
      $display("shamir_secret_recombine_gf16_unit_test: clean");
    end else begin
      $display("shamir_secret_recombine_gf16_unit_test: errors");
    end
    $finish;
  end

endmodule
